/* design/lrsw_pkg.sv */
package lrsw_pkg;

    // Request and result payloads
    typedef struct packed {
        logic       operation;
        logic [9:0] delta_ms;
        logic [7:0] pixel_index;
        logic       active_mode;
    } lrsw_req_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] level;
        logic       out_of_zone;
    } lrsw_pix_t;

    // Request operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_BREATH_BASE  = 3'd0,
        REG_BREATH_PEAK  = 3'd1,
        REG_BREATH_PER   = 3'd2,
        REG_STROBE_IDLE  = 3'd3,
        REG_STROBE_PEAK  = 3'd4,
        REG_STROBE_HALF  = 3'd5,
        REG_RING_DELAY   = 3'd6,
        REG_WAVE_REPEAT  = 3'd7
    } lrsw_reg_idx_t;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DISP = 9'b000000010,
        ST_ACT  = 9'b000000100,
        ST_DIV  = 9'b000001000,
        ST_FOLD = 9'b000010000,
        ST_WIN  = 9'b000100000,
        ST_MULA = 9'b001000000,
        ST_MULB = 9'b010000000,
        ST_EMIT = 9'b100000000
    } lrsw_state_t;

    // What a finished division feeds
    typedef enum logic [1:0] {
        PH_TICK = 2'd0,
        PH_AMB  = 2'd1,
        PH_ACT  = 2'd2,
        PH_FIN  = 2'd3
    } lrsw_phase_t;

    // Register reset values
    localparam logic [7:0]  RST_BREATH_BASE = 8'd10;
    localparam logic [7:0]  RST_BREATH_PEAK = 8'd31;
    localparam logic [21:0] RST_BREATH_PER  = 22'd3300000;
    localparam logic [7:0]  RST_STROBE_IDLE = 8'd20;
    localparam logic [7:0]  RST_STROBE_PEAK = 8'd217;
    localparam logic [17:0] RST_STROBE_HALF = 18'd41667;
    localparam logic [19:0] RST_RING_DELAY  = 20'd120000;
    localparam logic [23:0] RST_WAVE_REPEAT = 24'd1000000;

    // Colour of an in-zone pixel
    localparam logic [7:0] ZONE_HUE = 8'd171;
    localparam logic [7:0] ZONE_SAT = 8'd255;

    localparam logic [19:0] US_PER_MS = 20'd1000;

    // Shared divider: 30-bit dividend (largest is 255 * breathing period),
    // 22-bit divisor, one quotient bit per cycle
    localparam int DIV_W     = 30;
    localparam int DSR_W     = 22;
    localparam int DIV_STEPS = 30;
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 25;

endpackage

/* design/led_ring_strobe_wave_animator.sv */
// Channel   | Direction | Handshake            | Payload
// s_        | in        | s_valid / s_ready    | s_req  (lrsw_req_t)
// m_        | out       | m_valid / m_ready    | m_pix  (lrsw_pix_t)
// apb       | in/out    | psel, penable, pready| paddr, pwdata, prdata
//
// Work from acceptance to the earliest next acceptance, output register free:
// tick: dispatch plus one 30-step division of the phase sum; ambient render
// and active render in the on half of a flash: two 30-step divisions plus
// sequencing; active render in the off half: one 30-step division; black and
// idle level outside the flash window: no division.
// Reset clears all timers and loads the register defaults; no clearing pass.
// A waiting result sits in the output register; the next request is taken
// meanwhile, and the sequencer stalls in its emit step only if it is still full.
module led_ring_strobe_wave_animator import lrsw_pkg::*; #(
    parameter int PIXELS_PER_RING = 16,
    parameter int ZONE_PIXELS     = 128,
    parameter int STROBE_FLASHES  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lrsw_req_t   s_req,
    output logic        m_valid,
    input  logic        m_ready,
    output lrsw_pix_t   m_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [TIME_W-1:0] PAIR_MULT = TIME_W'(2 * STROBE_FLASHES);
    localparam logic [DSR_W-1:0]  FLASH_DIV = DSR_W'(STROBE_FLASHES - 1);
    localparam logic [8:0]        ZONE_LIM  = 9'(ZONE_PIXELS);

    // Registers
    lrsw_state_t       state_reg,  state_next;
    lrsw_phase_t       phase_reg,  phase_next;
    lrsw_req_t         req_reg,    req_next;
    logic [7:0]        base_reg,   base_next;
    logic [7:0]        bpeak_reg,  bpeak_next;
    logic [21:0]       period_reg, period_next;
    logic [7:0]        idle_reg,   idle_next;
    logic [7:0]        speak_reg,  speak_next;
    logic [17:0]       half_reg,   half_next;
    logic [19:0]       rdelay_reg, rdelay_next;
    logic [23:0]       repeat_reg, repeat_next;
    logic [21:0]       be_reg,     be_next;
    logic              run_reg,    run_next;
    logic [TIME_W-1:0] we_reg,     we_next;
    logic [TIME_W-1:0] rt_reg,     rt_next;
    logic [DIV_W-1:0]  dquo_reg,   dquo_next;
    logic [DSR_W-1:0]  drem_reg,   drem_next;
    logic [DSR_W-1:0]  ddsr_reg,   ddsr_next;
    logic [CNT_W-1:0]  dcnt_reg,   dcnt_next;
    logic [DIV_W-1:0]  acc_reg,    acc_next;
    logic [DSR_W-1:0]  opb_reg,    opb_next;
    logic [7:0]        lvl_reg,    lvl_next;
    logic              oz_reg,     oz_next;
    logic              mv_reg,     mv_next;
    lrsw_pix_t         mpix_reg,   mpix_next;

    // Combinational helpers
    logic              cfg_wr;
    lrsw_reg_idx_t     cfg_idx;
    logic [DSR_W-1:0]  eff_p;
    logic [19:0]       d_us;
    logic [TIME_W-1:0] pair_total;
    logic [TIME_W-1:0] wave_total;
    logic [TIME_W-1:0] rt_sum;
    logic [TIME_W-1:0] we_sum;
    logic [22:0]       be_sum;
    logic [1:0]        ring_dist;
    logic [TIME_W-1:0] start_us;
    logic [TIME_W-1:0] pe_us;
    logic [DSR_W:0]    dshift;
    logic [DSR_W:0]    dsub;
    logic              dge;
    logic [DSR_W-1:0]  rem_step;
    logic [DIV_W-1:0]  quo_step;
    logic [22:0]       fold_x;
    logic [22:0]       fold_num;
    logic [7:0]        mul_a;
    logic [DSR_W-1:0]  mul_b;
    logic [DIV_W-1:0]  prod;
    logic              out_free;

    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign m_pix    = mpix_reg;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = lrsw_reg_idx_t'(paddr[4:2]);
    assign out_free = ~mv_reg | m_ready;

    // Register read-back
    always_comb begin
        case (cfg_idx)
            REG_BREATH_BASE: prdata = 32'(base_reg);
            REG_BREATH_PEAK: prdata = 32'(bpeak_reg);
            REG_BREATH_PER:  prdata = 32'(period_reg);
            REG_STROBE_IDLE: prdata = 32'(idle_reg);
            REG_STROBE_PEAK: prdata = 32'(speak_reg);
            REG_STROBE_HALF: prdata = 32'(half_reg);
            REG_RING_DELAY:  prdata = 32'(rdelay_reg);
            REG_WAVE_REPEAT: prdata = 32'(repeat_reg);
            default:         prdata = '0;
        endcase
    end

    // Timing terms
    assign eff_p      = (period_reg == '0) ? DSR_W'(1) : period_reg;
    assign d_us       = 20'(req_reg.delta_ms) * US_PER_MS;
    assign pair_total = TIME_W'(half_reg) * PAIR_MULT;
    assign wave_total = TIME_W'(rdelay_reg) * TIME_W'(3) + pair_total;
    assign rt_sum     = rt_reg + TIME_W'(d_us);
    assign we_sum     = we_reg + TIME_W'(d_us);
    assign be_sum     = 23'(be_reg) + 23'(d_us);

    // Ring distance from centre: count ring boundaries at or below the pixel
    always_comb begin
        logic [2:0] ring;
        ring = '0;
        for (int k = 1; k < 8; k++) begin
            if (9'(req_reg.pixel_index) >= 9'(k * PIXELS_PER_RING)) begin
                ring = ring + 3'd1;
            end
        end
        case (ring)
            3'd3, 3'd4: ring_dist = 2'd0;
            3'd2, 3'd5: ring_dist = 2'd1;
            3'd1, 3'd6: ring_dist = 2'd2;
            default:    ring_dist = 2'd3;
        endcase
    end

    assign start_us = TIME_W'(rdelay_reg) * TIME_W'(ring_dist);
    assign pe_us    = we_reg - start_us;

    // Shared restoring divider step
    assign dshift   = {drem_reg, dquo_reg[DIV_W-1]};
    assign dsub     = dshift - {1'b0, ddsr_reg};
    assign dge      = (dshift >= {1'b0, ddsr_reg});
    assign rem_step = dge ? dsub[DSR_W-1:0] : dshift[DSR_W-1:0];
    assign quo_step = {dquo_reg[DIV_W-2:0], dge};

    // Triangle fold of the breathing phase
    assign fold_x   = {drem_reg, 1'b0};
    assign fold_num = (fold_x < {1'b0, eff_p}) ? fold_x : ({eff_p, 1'b0} - fold_x);

    // Shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MULA: begin
                if (req_reg.active_mode) begin
                    mul_a = speak_reg;
                    mul_b = FLASH_DIV - opb_reg;
                end else begin
                    mul_a = base_reg;
                    mul_b = eff_p - opb_reg;
                end
            end
            ST_MULB: begin
                mul_a = req_reg.active_mode ? idle_reg : bpeak_reg;
                mul_b = opb_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = DIV_W'(mul_a) * DIV_W'(mul_b);

    // Sequencer and state updates
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        req_next    = req_reg;
        base_next   = base_reg;
        bpeak_next  = bpeak_reg;
        period_next = period_reg;
        idle_next   = idle_reg;
        speak_next  = speak_reg;
        half_next   = half_reg;
        rdelay_next = rdelay_reg;
        repeat_next = repeat_reg;
        be_next     = be_reg;
        run_next    = run_reg;
        we_next     = we_reg;
        rt_next     = rt_reg;
        dquo_next   = dquo_reg;
        drem_next   = drem_reg;
        ddsr_next   = ddsr_reg;
        dcnt_next   = dcnt_reg;
        acc_next    = acc_reg;
        opb_next    = opb_reg;
        lvl_next    = lvl_reg;
        oz_next     = oz_reg;
        mv_next     = mv_reg;
        mpix_next   = mpix_reg;

        // result taken downstream
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        // configuration writes
        if (cfg_wr) begin
            case (cfg_idx)
                REG_BREATH_BASE: base_next   = pwdata[7:0];
                REG_BREATH_PEAK: bpeak_next  = pwdata[7:0];
                REG_BREATH_PER:  period_next = pwdata[21:0];
                REG_STROBE_IDLE: idle_next   = pwdata[7:0];
                REG_STROBE_PEAK: speak_next  = pwdata[7:0];
                REG_STROBE_HALF: half_next   = pwdata[17:0];
                REG_RING_DELAY:  rdelay_next = pwdata[19:0];
                REG_WAVE_REPEAT: repeat_next = pwdata[23:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    state_next = ST_DISP;
                end
            end

            ST_DISP: begin
                oz_next = 1'b0;
                if (req_reg.operation == OP_TICK) begin
                    // wave timers
                    if (!run_reg) begin
                        if (rt_sum >= TIME_W'(repeat_reg)) begin
                            run_next = 1'b1;
                            we_next  = '0;
                            rt_next  = '0;
                        end else begin
                            rt_next = rt_sum;
                        end
                    end else begin
                        if (we_sum >= wave_total) begin
                            run_next = 1'b0;
                            we_next  = '0;
                        end else begin
                            we_next = we_sum;
                        end
                    end
                    // breathing phase wraps through the divider
                    dquo_next  = DIV_W'(be_sum);
                    drem_next  = '0;
                    ddsr_next  = eff_p;
                    dcnt_next  = '0;
                    phase_next = PH_TICK;
                    state_next = ST_DIV;
                end else if (9'(req_reg.pixel_index) >= ZONE_LIM) begin
                    oz_next    = 1'b1;
                    lvl_next   = '0;
                    state_next = ST_EMIT;
                end else if (!req_reg.active_mode) begin
                    dquo_next  = DIV_W'(be_reg);
                    drem_next  = '0;
                    ddsr_next  = eff_p;
                    dcnt_next  = '0;
                    phase_next = PH_AMB;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_ACT;
                end
            end

            // position of this ring pair within the wave
            ST_ACT: begin
                if (!run_reg || (we_reg < start_us) || (pe_us >= pair_total) ||
                    (half_reg == '0)) begin
                    lvl_next   = idle_reg;
                    state_next = ST_EMIT;
                end else begin
                    dquo_next  = DIV_W'(pe_us);
                    drem_next  = '0;
                    ddsr_next  = DSR_W'({half_reg, 1'b0});
                    dcnt_next  = '0;
                    phase_next = PH_ACT;
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                dquo_next = quo_step;
                drem_next = rem_step;
                dcnt_next = dcnt_reg + CNT_W'(1);
                if (dcnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    case (phase_reg)
                        PH_TICK: begin
                            be_next    = rem_step;
                            state_next = ST_IDLE;
                        end
                        PH_AMB:  state_next = ST_FOLD;
                        PH_ACT:  state_next = ST_WIN;
                        PH_FIN: begin
                            lvl_next   = quo_step[7:0];
                            state_next = ST_EMIT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_FOLD: begin
                opb_next   = fold_num[DSR_W-1:0];
                state_next = ST_MULA;
            end

            // on or off half of the current flash
            ST_WIN: begin
                if (drem_reg >= DSR_W'(half_reg)) begin
                    lvl_next   = idle_reg;
                    state_next = ST_EMIT;
                end else begin
                    opb_next   = dquo_reg[DSR_W-1:0];
                    state_next = ST_MULA;
                end
            end

            ST_MULA: begin
                acc_next   = prod;
                state_next = ST_MULB;
            end

            // blend sum into the divider
            ST_MULB: begin
                dquo_next  = acc_reg + prod;
                drem_next  = '0;
                ddsr_next  = req_reg.active_mode ? FLASH_DIV : eff_p;
                dcnt_next  = '0;
                phase_next = PH_FIN;
                state_next = ST_DIV;
            end

            ST_EMIT: begin
                if (out_free) begin
                    mv_next               = 1'b1;
                    mpix_next.hue         = oz_reg ? 8'd0 : ZONE_HUE;
                    mpix_next.saturation  = oz_reg ? 8'd0 : ZONE_SAT;
                    mpix_next.level       = lvl_reg;
                    mpix_next.out_of_zone = oz_reg;
                    state_next            = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_TICK;
            base_reg   <= RST_BREATH_BASE;
            bpeak_reg  <= RST_BREATH_PEAK;
            period_reg <= RST_BREATH_PER;
            idle_reg   <= RST_STROBE_IDLE;
            speak_reg  <= RST_STROBE_PEAK;
            half_reg   <= RST_STROBE_HALF;
            rdelay_reg <= RST_RING_DELAY;
            repeat_reg <= RST_WAVE_REPEAT;
            be_reg     <= '0;
            run_reg    <= 1'b0;
            we_reg     <= '0;
            rt_reg     <= '0;
            dcnt_reg   <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            bpeak_reg  <= bpeak_next;
            period_reg <= period_next;
            idle_reg   <= idle_next;
            speak_reg  <= speak_next;
            half_reg   <= half_next;
            rdelay_reg <= rdelay_next;
            repeat_reg <= repeat_next;
            be_reg     <= be_next;
            run_reg    <= run_next;
            we_reg     <= we_next;
            rt_reg     <= rt_next;
            dcnt_reg   <= dcnt_next;
            mv_reg     <= mv_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        dquo_reg <= dquo_next;
        drem_reg <= drem_next;
        ddsr_reg <= ddsr_next;
        acc_reg  <= acc_next;
        opb_reg  <= opb_next;
        lvl_reg  <= lvl_next;
        oz_reg   <= oz_next;
        mpix_reg <= mpix_next;
    end

`ifndef ASSERT_OFF
    // a running wave always restarts its repeat timer from zero
    a_run_rt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (rt_reg == '0))
        else $error("repeat timer not cleared while wave runs");

    // wave time is held at zero while no wave runs
    a_idle_we_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg |-> (we_reg == '0))
        else $error("wave time non-zero with no wave");

    // the divider never sees a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (ddsr_reg != '0))
        else $error("zero divisor in shared divider");

    // an accepted request is dispatched next cycle
    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISP))
        else $error("accepted request not dispatched");

    // the divider step count stays in range
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dcnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");
`endif

endmodule

/* tb/tb_led_ring_strobe_wave_animator.sv */
module tb_led_ring_strobe_wave_animator import lrsw_pkg::*;;

    // Scoreboard: keeps its own copy of the timers and registers and predicts
    // one pixel per render request
    class animator_scoreboard;
        localparam int RING_PIX = 16;
        localparam int ZONE     = 128;
        localparam int FLASHES  = 8;

        // register copies
        bit [7:0]  base_lvl;
        bit [7:0]  crest_lvl;
        bit [21:0] breath_per;
        bit [7:0]  idle_lvl;
        bit [7:0]  flash_lvl;
        bit [17:0] half_us;
        bit [19:0] ring_us;
        bit [23:0] repeat_us;

        // timers
        bit [21:0] breath_pos;
        bit        wave_on;
        bit [24:0] wave_pos;
        bit [24:0] repeat_pos;

        lrsw_pix_t pending_pixels[$];
        int        errors;

        function new();
            base_lvl   = RST_BREATH_BASE;
            crest_lvl  = RST_BREATH_PEAK;
            breath_per = RST_BREATH_PER;
            idle_lvl   = RST_STROBE_IDLE;
            flash_lvl  = RST_STROBE_PEAK;
            half_us    = RST_STROBE_HALF;
            ring_us    = RST_RING_DELAY;
            repeat_us  = RST_WAVE_REPEAT;
            breath_pos = '0;
            wave_on    = 1'b0;
            wave_pos   = '0;
            repeat_pos = '0;
            errors     = 0;
        endfunction

        function void set_reg(lrsw_reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_BREATH_BASE: base_lvl   = v[7:0];
                REG_BREATH_PEAK: crest_lvl  = v[7:0];
                REG_BREATH_PER:  breath_per = v[21:0];
                REG_STROBE_IDLE: idle_lvl   = v[7:0];
                REG_STROBE_PEAK: flash_lvl  = v[7:0];
                REG_STROBE_HALF: half_us    = v[17:0];
                REG_RING_DELAY:  ring_us    = v[19:0];
                REG_WAVE_REPEAT: repeat_us  = v[23:0];
                default: ;
            endcase
        endfunction

        function int ring_dist(int ring);
            case (ring)
                3, 4:    return 0;
                2, 5:    return 1;
                1, 6:    return 2;
                default: return 3;
            endcase
        endfunction

        // triangle between base and crest; a zero period counts as 1 us
        function bit [7:0] breath_level();
            longint unsigned p, e, x, num, sum;
            p = (breath_per == 0) ? 1 : breath_per;
            e = breath_pos % p;
            x = 2 * e;
            num = (x < p) ? x : (2 * p - x);
            sum = base_lvl * (p - num) + crest_lvl * num;
            return 8'(sum / p);
        endfunction

        // strobe level of one pixel while the wave sweeps outward
        function bit [7:0] flash_level(bit [7:0] pixel);
            longint unsigned start, pe, pair, full, cyc, cyc_pos, sum;
            if (!wave_on)
                return idle_lvl;
            start = ring_dist(pixel / RING_PIX) * ring_us;
            if (wave_pos < start)
                return idle_lvl;
            pe = wave_pos - start;
            pair = FLASHES * 2 * half_us;
            if (pe >= pair || half_us == 0)
                return idle_lvl;
            full = 2 * half_us;
            cyc = pe / full;
            cyc_pos = pe - cyc * full;
            if (cyc_pos >= half_us)
                return idle_lvl;
            sum = flash_lvl * (FLASHES - 1 - cyc) + idle_lvl * cyc;
            return 8'(sum / (FLASHES - 1));
        endfunction

        function void note_request(lrsw_req_t r);
            longint unsigned d, per, total;
            lrsw_pix_t px;
            if (r.operation == OP_TICK) begin
                d = r.delta_ms * 1000;
                per = (breath_per == 0) ? 1 : breath_per;
                breath_pos = 22'((breath_pos + d) % per);
                if (!wave_on) begin
                    repeat_pos = 25'(repeat_pos + d);
                    if (repeat_pos >= repeat_us) begin
                        wave_on = 1'b1;
                        wave_pos = '0;
                        repeat_pos = '0;
                    end
                end else begin
                    total = 3 * ring_us + FLASHES * 2 * half_us;
                    wave_pos = 25'(wave_pos + d);
                    if (wave_pos >= total) begin
                        wave_on = 1'b0;
                        wave_pos = '0;
                    end
                end
                return;
            end
            if (r.pixel_index >= ZONE) begin
                px.hue = '0;
                px.saturation = '0;
                px.level = '0;
                px.out_of_zone = 1'b1;
            end else begin
                px.hue = ZONE_HUE;
                px.saturation = ZONE_SAT;
                px.level = r.active_mode ? flash_level(r.pixel_index) : breath_level();
                px.out_of_zone = 1'b0;
            end
            pending_pixels.push_back(px);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] pixel mismatch: %s", $time, msg);
        endtask

        task check_pixel(lrsw_pix_t got);
            lrsw_pix_t want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %h", got));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.hue !== want.hue)
                report($sformatf("hue %0d, want %0d", got.hue, want.hue));
            if (got.saturation !== want.saturation)
                report($sformatf("saturation %0d, want %0d", got.saturation,
                                 want.saturation));
            if (got.level !== want.level)
                report($sformatf("level %0d, want %0d", got.level, want.level));
            if (got.out_of_zone !== want.out_of_zone)
                report($sformatf("out_of_zone %0b, want %0b", got.out_of_zone,
                                 want.out_of_zone));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 80;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 48;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lrsw_req_t   s_req;
    logic        m_valid;
    logic        m_ready;
    lrsw_pix_t   m_pix;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    animator_scoreboard sb = new();
    int cycle_count = 0;
    int src_calm;
    int stall_left = 0;
    int open_left = 0;
    int rdy_roll;

    led_ring_strobe_wave_animator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_pix   (m_pix),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_pix);
    end

    // result back-pressure: short and long stalls, plus open stretches
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (open_left > 0) begin
            open_left--;
            m_ready = 1'b1;
        end else begin
            m_ready = 1'b1;
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 8)
                open_left = $urandom_range(20, 80);
            else if (rdy_roll < 30)
                stall_left = $urandom_range(1, 3);
            else if (rdy_roll < 33)
                stall_left = $urandom_range(8, 40);
            else if (rdy_roll < 34)
                stall_left = $urandom_range(60, 150);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (src_calm != 0 || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 200);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input lrsw_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req = r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic op, input int delta, input int pix,
                               input logic act);
        lrsw_req_t r;
        r.operation = op;
        r.delta_ms = 10'(delta);
        r.pixel_index = 8'(pix);
        r.active_mode = act;
        send_req(r);
    endtask

    function automatic lrsw_req_t make_request(int max_delta);
        lrsw_req_t r;
        r.operation = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_RENDER;
        if ($urandom_range(0, 15) == 0)
            r.delta_ms = 10'($urandom_range(0, 1023));
        else
            r.delta_ms = 10'($urandom_range(0, max_delta));
        if ($urandom_range(0, 7) == 0)
            r.pixel_index = 8'($urandom_range(128, 255));
        else
            r.pixel_index = 8'($urandom_range(0, 127));
        r.active_mode = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // let every outstanding request finish before touching registers
    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input lrsw_reg_idx_t idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // register set per phase: extremes and special cases first, then random
    task automatic apply_settings(input int phase);
        logic [31:0] vals[8];
        case (phase)
            1: begin
                vals[REG_BREATH_BASE] = 0;
                vals[REG_BREATH_PEAK] = 255;
                vals[REG_BREATH_PER]  = 4194303;
                vals[REG_STROBE_IDLE] = 0;
                vals[REG_STROBE_PEAK] = 255;
                vals[REG_STROBE_HALF] = 3000;
                vals[REG_RING_DELAY]  = 5000;
                vals[REG_WAVE_REPEAT] = 2000;
            end
            2: begin
                // short period after a long one leaves the phase beyond it
                vals[REG_BREATH_BASE] = 255;
                vals[REG_BREATH_PEAK] = 0;
                vals[REG_BREATH_PER]  = 1000;
                vals[REG_STROBE_IDLE] = 255;
                vals[REG_STROBE_PEAK] = 0;
                vals[REG_STROBE_HALF] = 1;
                vals[REG_RING_DELAY]  = 0;
                vals[REG_WAVE_REPEAT] = 0;
            end
            3: begin
                // zero breathing period, zero strobe half period
                vals[REG_BREATH_BASE] = 37;
                vals[REG_BREATH_PEAK] = 200;
                vals[REG_BREATH_PER]  = 0;
                vals[REG_STROBE_IDLE] = 99;
                vals[REG_STROBE_PEAK] = 3;
                vals[REG_STROBE_HALF] = 0;
                vals[REG_RING_DELAY]  = 1048575;
                vals[REG_WAVE_REPEAT] = 500;
            end
            4: begin
                vals[REG_BREATH_BASE] = 128;
                vals[REG_BREATH_PEAK] = 127;
                vals[REG_BREATH_PER]  = 1;
                vals[REG_STROBE_IDLE] = 1;
                vals[REG_STROBE_PEAK] = 254;
                vals[REG_STROBE_HALF] = 262143;
                vals[REG_RING_DELAY]  = 1000;
                vals[REG_WAVE_REPEAT] = 16777215;
            end
            default: begin
                vals[REG_BREATH_BASE] = $urandom_range(0, 255);
                vals[REG_BREATH_PEAK] = $urandom_range(0, 255);
                vals[REG_BREATH_PER]  = ($urandom_range(0, 3) == 0) ?
                                        $urandom_range(1, 5000) : $urandom_range(1, 4194303);
                vals[REG_STROBE_IDLE] = $urandom_range(0, 255);
                vals[REG_STROBE_PEAK] = $urandom_range(0, 255);
                vals[REG_STROBE_HALF] = $urandom_range(200, 20000);
                vals[REG_RING_DELAY]  = $urandom_range(0, 30000);
                vals[REG_WAVE_REPEAT] = $urandom_range(0, 50000);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(lrsw_reg_idx_t'(i), vals[i]);
    endtask

    initial begin
        longint unsigned span;
        int max_delta;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_calm = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed walk through one wave at the reset settings
        send_fields(OP_RENDER, 0, 0, 1'b0);
        send_fields(OP_RENDER, 0, 127, 1'b0);
        send_fields(OP_RENDER, 0, 128, 1'b0);
        send_fields(OP_RENDER, 0, 255, 1'b1);
        send_fields(OP_RENDER, 0, 64, 1'b1);
        send_fields(OP_TICK, 0, 0, 1'b0);
        send_fields(OP_TICK, 1023, 255, 1'b1);   // starts the wave
        send_fields(OP_RENDER, 0, 48, 1'b1);
        send_fields(OP_RENDER, 0, 0, 1'b1);
        send_fields(OP_RENDER, 0, 79, 1'b0);
        send_fields(OP_TICK, 40, 0, 1'b0);
        send_fields(OP_RENDER, 0, 70, 1'b1);
        send_fields(OP_RENDER, 0, 40, 1'b1);
        send_fields(OP_TICK, 100, 0, 1'b0);
        send_fields(OP_RENDER, 0, 33, 1'b1);
        send_fields(OP_RENDER, 0, 50, 1'b1);
        send_fields(OP_TICK, 50, 0, 1'b0);      // third flash of the centre rings
        send_fields(OP_RENDER, 0, 60, 1'b1);
        send_fields(OP_RENDER, 0, 100, 1'b1);
        send_fields(OP_TICK, 1023, 0, 1'b0);    // wave ends
        send_fields(OP_RENDER, 0, 64, 1'b1);
        send_fields(OP_TICK, 1023, 0, 1'b0);
        send_fields(OP_TICK, 200, 0, 1'b0);     // breathing wraps during the next wave
        send_fields(OP_RENDER, 1023, 255, 1'b0);
        send_fields(OP_RENDER, 0, 20, 1'b0);

        // random phases, each under its own register set
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                apply_settings(p);
            end
            src_calm = (p % 3 == 2);
            span = sb.repeat_us + 3 * sb.ring_us + 16 * sb.half_us;
            max_delta = (span / 12000 > 1022) ? 1023 : int'(span / 12000) + 1;
            for (int i = 0; i < PHASE_REQS; i++)
                send_req(make_request(max_delta));
        end

        wait_drained();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* led_ring_strobe_wave_animator.f */
design/lrsw_pkg.sv
design/led_ring_strobe_wave_animator.sv
tb/tb_led_ring_strobe_wave_animator.sv
